// ----- rtl/ssuf_pkg.sv -----
package ssuf_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int SWEEP_W  = 20;
    localparam int SUM_W    = 18;

    // Configuration register indexes
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_MAX_SWEEPS = 1'b1;

    localparam logic [SAMPLE_W-1:0] TOLERANCE_RST  = 16'd655;
    localparam logic [SWEEP_W-1:0]  MAX_SWEEPS_RST = 20'hFFFFF;

    // Result status codes
    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_LIMIT     = 2'd1;
    localparam logic [1:0] STAT_SHORT     = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

    // floor(s / 3) = (s * DIV3_MUL) >> DIV3_SHIFT for every s below 2**19
    localparam logic [SUM_W-1:0] DIV3_MUL   = 18'd174763;
    localparam int               DIV3_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHIFT,
        ST_SUM,
        ST_MUL,
        ST_WRITE,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic sum_en;
        logic mul_en;
        logic first;
        logic last;
    } avg_ctl_t;

endpackage

// ----- rtl/smoothing_stencil_until_flat.sv -----
// Channel   Handshake              Fields
// -------   ---------------------  -------------------------------------
// input     start && !busy         sample[15:0], last
// result    done (one cycle)       sweeps[19:0], status[1:0]
// config    cfg_we                 cfg_index, cfg_data[19:0]
//
// Loading accepts one sample per cycle; busy stays low while samples stream in.
// After the last sample the block sweeps over the n elements one at a time: one
// averaging unit (add, reciprocal multiply) and one read port per bank are
// shared across all elements, and busy is high until the result beat.
// The result beat is shown in the cycle after the final decision; the receiver
// cannot stall it. Reset clears control state; the vector memories are not cleared.
module smoothing_stencil_until_flat #(
    parameter int CAPACITY = ssuf_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ssuf_pkg::SAMPLE_W-1:0]      sample,
    input  logic                               last,
    output logic                               done,
    output logic [ssuf_pkg::SWEEP_W-1:0]       sweeps,
    output logic [1:0]                         status,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [ssuf_pkg::SWEEP_W-1:0]       cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    ssuf_pkg::state_t state_reg, state_next;

    logic                           bank_reg, bank_next;
    logic [CW-1:0]                  load_cnt_reg, load_cnt_next;
    logic                           ovf_reg, ovf_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [CW-1:0]                  elem_reg, elem_next;
    logic [AW-1:0]                  fetch_addr_reg, fetch_addr_next;
    logic                           prime_reg, prime_next;
    logic                           within_reg, within_next;
    logic                           same_reg, same_next;
    logic [ssuf_pkg::SWEEP_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic [ssuf_pkg::SAMPLE_W-1:0]  tol_reg;
    logic [ssuf_pkg::SWEEP_W-1:0]   max_reg;
    logic                           done_reg, done_next;
    logic [ssuf_pkg::SWEEP_W-1:0]   sweeps_reg, sweeps_next;
    logic [1:0]                     status_reg, status_next;

    logic [ssuf_pkg::SAMPLE_W-1:0]  a_reg, a_next;
    logic [ssuf_pkg::SAMPLE_W-1:0]  b_reg, b_next;
    logic [ssuf_pkg::SAMPLE_W-1:0]  c_reg, c_next;
    logic [ssuf_pkg::SAMPLE_W-1:0]  first_val_reg, first_val_next;

    logic [ssuf_pkg::SAMPLE_W-1:0]  mem0 [CAPACITY];
    logic [ssuf_pkg::SAMPLE_W-1:0]  mem1 [CAPACITY];
    logic [ssuf_pkg::SAMPLE_W-1:0]  rd0_reg;
    logic [ssuf_pkg::SAMPLE_W-1:0]  rd1_reg;
    logic [ssuf_pkg::SAMPLE_W-1:0]  rdata;

    logic                           wr_en;
    logic                           wr_bank;
    logic [AW-1:0]                  wr_addr;
    logic [ssuf_pkg::SAMPLE_W-1:0]  wr_data;

    ssuf_pkg::avg_ctl_t             avg_ctl;
    logic [ssuf_pkg::SAMPLE_W-1:0]  avg;
    logic [ssuf_pkg::SAMPLE_W-1:0]  ref_val;
    logic [ssuf_pkg::SAMPLE_W-1:0]  diff;
    logic [ssuf_pkg::SWEEP_W-1:0]   cnt_inc;
    logic [ssuf_pkg::SWEEP_W-1:0]   limit;
    logic                           is_last_elem;

    ssuf_avg u_avg (
        .clk (clk),
        .ctl (avg_ctl),
        .a   (a_reg),
        .b   (b_reg),
        .c   (c_reg),
        .avg (avg)
    );

    // Vector banks: bank_reg selects the current vector, the other takes the sweep output
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
            mem0[wr_addr] <= wr_data;
        if (wr_en && wr_bank)
            mem1[wr_addr] <= wr_data;
        rd0_reg <= mem0[fetch_addr_reg];
        rd1_reg <= mem1[fetch_addr_reg];
    end

    assign rdata = bank_reg ? rd1_reg : rd0_reg;

    assign is_last_elem = (elem_reg == n_reg - CW'(1));
    assign ref_val = (elem_reg == '0) ? avg : first_val_reg;
    assign diff = (avg >= ref_val) ? (avg - ref_val) : (ref_val - avg);
    assign cnt_inc = sweep_cnt_reg + ssuf_pkg::SWEEP_W'(1);
    assign limit = (max_reg == '0) ? ssuf_pkg::SWEEP_W'(1) : max_reg;

    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        load_cnt_next   = load_cnt_reg;
        ovf_next        = ovf_reg;
        n_next          = n_reg;
        elem_next       = elem_reg;
        fetch_addr_next = fetch_addr_reg;
        prime_next      = prime_reg;
        within_next     = within_reg;
        same_next       = same_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        done_next       = 1'b0;
        sweeps_next     = sweeps_reg;
        status_next     = status_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        first_val_next  = first_val_reg;
        wr_en           = 1'b0;
        wr_bank         = bank_reg;
        wr_addr         = load_cnt_reg[AW-1:0];
        wr_data         = sample;
        avg_ctl         = '0;

        unique case (state_reg)
            ssuf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (load_cnt_reg < CAP_W)
                    begin
                        wr_en         = 1'b1;
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        load_cnt_next = '0;
                        ovf_next      = 1'b0;
                        if (ovf_reg || load_cnt_reg == CAP_W)
                        begin
                            done_next   = 1'b1;
                            sweeps_next = '0;
                            status_next = ssuf_pkg::STAT_OVERFLOW;
                        end
                        else if (load_cnt_reg == '0)
                        begin
                            done_next   = 1'b1;
                            sweeps_next = '0;
                            status_next = ssuf_pkg::STAT_SHORT;
                        end
                        else
                        begin
                            n_next          = load_cnt_reg + CW'(1);
                            elem_next       = '0;
                            fetch_addr_next = '0;
                            prime_next      = 1'b1;
                            within_next     = 1'b1;
                            same_next       = 1'b1;
                            sweep_cnt_next  = '0;
                            state_next      = ssuf_pkg::ST_FETCH;
                        end
                    end
                end
            end

            ssuf_pkg::ST_FETCH:
            begin
                state_next = ssuf_pkg::ST_SHIFT;
            end

            ssuf_pkg::ST_SHIFT:
            begin
                // Advance the three-element window
                a_next          = b_reg;
                b_next          = c_reg;
                c_next          = rdata;
                fetch_addr_next = fetch_addr_reg + AW'(1);
                if (prime_reg)
                begin
                    prime_next = 1'b0;
                    state_next = ssuf_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = ssuf_pkg::ST_SUM;
                end
            end

            ssuf_pkg::ST_SUM:
            begin
                avg_ctl.sum_en = 1'b1;
                avg_ctl.first  = (elem_reg == '0);
                avg_ctl.last   = is_last_elem;
                state_next     = ssuf_pkg::ST_MUL;
            end

            ssuf_pkg::ST_MUL:
            begin
                avg_ctl.mul_en = 1'b1;
                state_next     = ssuf_pkg::ST_WRITE;
            end

            ssuf_pkg::ST_WRITE:
            begin
                wr_en   = 1'b1;
                wr_bank = !bank_reg;
                wr_addr = elem_reg[AW-1:0];
                wr_data = avg;
                if (elem_reg == '0)
                    first_val_next = avg;
                if (diff > tol_reg)
                    within_next = 1'b0;
                if (avg != b_reg)
                    same_next = 1'b0;
                if (is_last_elem)
                begin
                    state_next = ssuf_pkg::ST_DECIDE;
                end
                else
                begin
                    elem_next  = elem_reg + CW'(1);
                    state_next = ssuf_pkg::ST_FETCH;
                end
            end

            ssuf_pkg::ST_DECIDE:
            begin
                bank_next = !bank_reg;
                if (within_reg)
                begin
                    done_next   = 1'b1;
                    sweeps_next = cnt_inc;
                    status_next = ssuf_pkg::STAT_CONVERGED;
                    state_next  = ssuf_pkg::ST_IDLE;
                end
                else if (cnt_inc >= limit)
                begin
                    done_next   = 1'b1;
                    sweeps_next = cnt_inc;
                    status_next = ssuf_pkg::STAT_LIMIT;
                    state_next  = ssuf_pkg::ST_IDLE;
                end
                else if (same_reg)
                begin
                    // Vector stuck: every later sweep repeats this one
                    done_next   = 1'b1;
                    sweeps_next = limit;
                    status_next = ssuf_pkg::STAT_LIMIT;
                    state_next  = ssuf_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_cnt_next  = cnt_inc;
                    elem_next       = '0;
                    fetch_addr_next = '0;
                    prime_next      = 1'b1;
                    within_next     = 1'b1;
                    same_next       = 1'b1;
                    state_next      = ssuf_pkg::ST_FETCH;
                end
            end

            default:
            begin
                state_next = ssuf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssuf_pkg::ST_IDLE;
            bank_reg      <= 1'b0;
            load_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            prime_reg     <= 1'b0;
            within_reg    <= 1'b1;
            same_reg      <= 1'b1;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
            tol_reg       <= ssuf_pkg::TOLERANCE_RST;
            max_reg       <= ssuf_pkg::MAX_SWEEPS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            load_cnt_reg  <= load_cnt_next;
            ovf_reg       <= ovf_next;
            prime_reg     <= prime_next;
            within_reg    <= within_next;
            same_reg      <= same_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ssuf_pkg::REG_TOLERANCE:  tol_reg <= cfg_data[ssuf_pkg::SAMPLE_W-1:0];
                    ssuf_pkg::REG_MAX_SWEEPS: max_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        elem_reg       <= elem_next;
        fetch_addr_reg <= fetch_addr_next;
        sweeps_reg     <= sweeps_next;
        status_reg     <= status_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        first_val_reg  <= first_val_next;
    end

    assign busy   = (state_reg != ssuf_pkg::ST_IDLE);
    assign done   = done_reg;
    assign sweeps = sweeps_reg;
    assign status = status_reg;

endmodule

// ----- rtl/ssuf_avg.sv -----
module ssuf_avg (
    input  logic                              clk,
    input  ssuf_pkg::avg_ctl_t                ctl,
    input  logic [ssuf_pkg::SAMPLE_W-1:0]     a,
    input  logic [ssuf_pkg::SAMPLE_W-1:0]     b,
    input  logic [ssuf_pkg::SAMPLE_W-1:0]     c,
    output logic [ssuf_pkg::SAMPLE_W-1:0]     avg
);

    logic [ssuf_pkg::SUM_W-1:0]     sum_reg;
    logic                           end_reg;
    logic [ssuf_pkg::SAMPLE_W-1:0]  avg_reg;
    logic [2*ssuf_pkg::SUM_W-1:0]   prod;
    logic [ssuf_pkg::SUM_W-1:0]     a_ext;
    logic [ssuf_pkg::SUM_W-1:0]     b_ext;
    logic [ssuf_pkg::SUM_W-1:0]     c_ext;

    assign a_ext = ssuf_pkg::SUM_W'(a);
    assign b_ext = ssuf_pkg::SUM_W'(b);
    assign c_ext = ssuf_pkg::SUM_W'(c);

    // Reciprocal multiply stands in for the divide by three
    assign prod = (2*ssuf_pkg::SUM_W)'(sum_reg) * (2*ssuf_pkg::SUM_W)'(ssuf_pkg::DIV3_MUL);

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            if (ctl.first)
                sum_reg <= b_ext + c_ext;
            else if (ctl.last)
                sum_reg <= a_ext + b_ext;
            else
                sum_reg <= a_ext + b_ext + c_ext;
            end_reg <= ctl.first | ctl.last;
        end
        if (ctl.mul_en)
        begin
            if (end_reg)
                avg_reg <= sum_reg[ssuf_pkg::SAMPLE_W:1];
            else
                avg_reg <= prod[ssuf_pkg::DIV3_SHIFT +: ssuf_pkg::SAMPLE_W];
        end
    end

    assign avg = avg_reg;

endmodule

// ----- rtl/ssuf_checker.sv -----
module ssuf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          last,
    input logic                          done,
    input logic [ssuf_pkg::SWEEP_W-1:0]  sweeps,
    input logic [1:0]                    status
);

    // A result beat never overlaps the sweep phase
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // A beat that is not the last one produces no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last) |=> !done)
        else $error("result after a non-last beat");

    // Sweeps begin only after the last beat is taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && last))
        else $error("busy rose without a last beat");

    // Rejected vectors report no sweeps
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ssuf_pkg::STAT_SHORT || status == ssuf_pkg::STAT_OVERFLOW))
            |-> (sweeps == '0))
        else $error("nonzero sweeps on rejected vector");

    // Swept vectors report at least one sweep
    a_swept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ssuf_pkg::STAT_CONVERGED || status == ssuf_pkg::STAT_LIMIT))
            |-> (sweeps != '0))
        else $error("zero sweeps on swept vector");

endmodule

bind smoothing_stencil_until_flat ssuf_checker u_ssuf_checker (.*);

// ----- test/smoothing_stencil_until_flat_tb.sv -----
`timescale 1ns / 100ps
module smoothing_stencil_until_flat_tb;
    import ssuf_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_beat_t;

    typedef struct packed {
        logic [SWEEP_W-1:0] sweeps;
        logic [1:0]         status;
    } settle_t;

    typedef enum {
        SHAPE_NOISE,
        SHAPE_RAMP,
        SHAPE_NEAR_FLAT,
        SHAPE_STUCK
    } shape_t;

    logic                clk;
    logic                rst_n;
    logic                start = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                last = 1'b0;
    logic                done;
    logic [SWEEP_W-1:0]  sweeps;
    logic [1:0]          status;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_TOLERANCE;
    logic [SWEEP_W-1:0]  cfg_data = '0;

    sample_beat_t sample_q[$];
    settle_t      settle_q[$];

    // model state
    logic [SAMPLE_W-1:0] cur_v[DEPTH];
    logic [SAMPLE_W-1:0] nxt_v[DEPTH];
    int unsigned         held_cnt = 0;
    bit                  spilled = 1'b0;
    logic [SAMPLE_W-1:0] tol_reg = TOLERANCE_RST;
    logic [SWEEP_W-1:0]  limit_reg = MAX_SWEEPS_RST;

    bit took = 1'b0;
    int fail_cnt = 0;
    int burst_left = 1;
    int gap_left = 0;

    smoothing_stencil_until_flat uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .last      (last),
        .done      (done),
        .sweeps    (sweeps),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report(input string what);
        fail_cnt++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Store one sample; on the last, relax until flat or limit and queue the result.
    task automatic load_and_settle(input logic [SAMPLE_W-1:0] s, input logic lst);
        int unsigned lim;
        int unsigned cnt;
        int unsigned sum;
        int unsigned d;
        int unsigned first;
        int          i;
        bit          flat;
        bit          same;
        settle_t     r;
        if (held_cnt < DEPTH)
        begin
            cur_v[held_cnt] = s;
            held_cnt++;
        end
        else
        begin
            spilled = 1'b1;
        end
        if (!lst)
            return;
        cnt = 0;
        if (spilled)
        begin
            r.status = STAT_OVERFLOW;
        end
        else if (held_cnt < 2)
        begin
            r.status = STAT_SHORT;
        end
        else
        begin
            lim = (limit_reg == '0) ? 32'd1 : 32'(limit_reg);
            r.status = STAT_LIMIT;
            forever
            begin
                sum = int'(cur_v[0]) + int'(cur_v[1]);
                nxt_v[0] = SAMPLE_W'(sum >> 1);
                sum = int'(cur_v[held_cnt-2]) + int'(cur_v[held_cnt-1]);
                nxt_v[held_cnt-1] = SAMPLE_W'(sum >> 1);
                for (i = 1; i + 1 < held_cnt; i++)
                begin
                    sum = int'(cur_v[i-1]) + int'(cur_v[i]) + int'(cur_v[i+1]);
                    nxt_v[i] = SAMPLE_W'(sum / 3);
                end
                first = 32'(nxt_v[0]);
                flat = 1'b1;
                same = 1'b1;
                for (i = 0; i < held_cnt; i++)
                begin
                    d = (nxt_v[i] > first) ? nxt_v[i] - first : first - nxt_v[i];
                    if (d > tol_reg)
                        flat = 1'b0;
                    if (nxt_v[i] != cur_v[i])
                        same = 1'b0;
                    cur_v[i] = nxt_v[i];
                end
                cnt++;
                if (flat)
                begin
                    r.status = STAT_CONVERGED;
                    break;
                end
                if (cnt >= lim)
                    break;
                // an unchanged, unconverged vector never moves again
                if (same)
                begin
                    cnt = lim;
                    break;
                end
            end
        end
        r.sweeps = cnt[SWEEP_W-1:0];
        settle_q.push_back(r);
        held_cnt = 0;
        spilled = 1'b0;
    endtask

    always @(posedge clk)
    begin : watch
        settle_t want;
        took = rst_n && start && !busy;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TOLERANCE)
                    tol_reg = cfg_data[SAMPLE_W-1:0];
                else
                    limit_reg = cfg_data;
            end
            if (done)
            begin
                if (settle_q.size() == 0)
                begin
                    report($sformatf("result beat sweeps=%0d status=%0d with nothing expected",
                                     sweeps, status));
                end
                else
                begin
                    want = settle_q.pop_front();
                    if (sweeps !== want.sweeps)
                        report($sformatf("sweeps %0d, expected %0d", sweeps, want.sweeps));
                    if (status !== want.status)
                        report($sformatf("status %0d, expected %0d", status, want.status));
                end
            end
            if (took)
                load_and_settle(sample, last);
        end
    end

    always @(negedge clk)
    begin : drive
        sample_beat_t b;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !took)
        begin
            // hold the beat until the block takes it
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (sample_q.size() > 0)
        begin
            b = sample_q.pop_front();
            sample <= b.sample;
            last <= b.last;
            start <= 1'b1;
            if (burst_left > 1)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    task automatic push_beat(input logic [SAMPLE_W-1:0] s, input logic l);
        sample_beat_t b;
        b.sample = s;
        b.last = l;
        sample_q.push_back(b);
    endtask

    task automatic push_vector(input int n, input shape_t shape);
        int i;
        int v;
        int base;
        int step;
        int spread;
        base = int'($urandom_range(0, 65535));
        step = int'($urandom_range(0, 512));
        if ($urandom_range(0, 1))
            step = -step;
        spread = 1 << $urandom_range(0, 12);
        if (shape == SHAPE_STUCK)
        begin
            // a, a+1, a+1 sits one step off flat and settles in a couple of sweeps
            base = int'($urandom_range(0, 65534));
            push_beat(SAMPLE_W'(base), 1'b0);
            push_beat(SAMPLE_W'(base + 1), 1'b0);
            push_beat(SAMPLE_W'(base + 1), 1'b1);
            return;
        end
        for (i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_NOISE: v = int'($urandom_range(0, 65535));
                SHAPE_RAMP:  v = base + i * step;
                default:     v = base + int'($urandom_range(0, spread - 1)) - spread / 2;
            endcase
            if (v < 0)
                v = 0;
            else if (v > 65535)
                v = 65535;
            push_beat(v[SAMPLE_W-1:0], i == n - 1);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [SWEEP_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every beat is in and every result is out, then let the block drain.
    task automatic quiesce();
        while (sample_q.size() != 0 || start || settle_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        int                 ph;
        int                 queued;
        int                 pick;
        int                 n;
        shape_t             shape;
        logic [SWEEP_W-1:0] tol;
        logic [SWEEP_W-1:0] lim;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: short vector, pair, flat vector
        push_beat(16'hFFFF, 1'b1);
        push_beat(16'h0000, 1'b0);
        push_beat(16'hFFFF, 1'b1);
        repeat (3) push_beat(16'h8000, 1'b0);
        push_beat(16'h8000, 1'b1);
        quiesce();

        // one sweep allowed: stop unconverged, and converge right at the limit
        write_reg(REG_TOLERANCE, 20'd0);
        write_reg(REG_MAX_SWEEPS, 20'd1);
        push_beat(16'h0000, 1'b0);
        push_beat(16'hFFFF, 1'b0);
        push_beat(16'h0000, 1'b0);
        push_beat(16'hFFFF, 1'b1);
        push_beat(16'd5, 1'b0);
        push_beat(16'd6, 1'b1);
        quiesce();

        // zero limit behaves as one
        write_reg(REG_MAX_SWEEPS, 20'd0);
        push_beat(16'h0000, 1'b0);
        push_beat(16'hFFFF, 1'b0);
        push_beat(16'h0000, 1'b1);
        quiesce();

        // a, a+1, a+1 vectors settle to flat under the full limit
        write_reg(REG_MAX_SWEEPS, 20'hFFFFF);
        push_beat(16'd100, 1'b0);
        push_beat(16'd101, 1'b0);
        push_beat(16'd101, 1'b1);
        push_beat(16'd65534, 1'b0);
        push_beat(16'd65535, 1'b0);
        push_beat(16'd65535, 1'b1);
        quiesce();

        write_reg(REG_TOLERANCE, 20'hFFFF);
        push_vector(3, SHAPE_NOISE);
        quiesce();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:       tol = 20'd0;
                1:       tol = 20'hFFFF;
                2:       tol = SWEEP_W'($urandom_range(0, 4095));
                default: tol = SWEEP_W'($urandom_range(0, 65535));
            endcase
            // keep the limit small unless every vector settles in one sweep
            if (tol == 20'hFFFF)
                lim = 20'hFFFFF;
            else if ($urandom_range(0, 5) == 0)
                lim = 20'd0;
            else
                lim = SWEEP_W'($urandom_range(1, 40));
            write_reg(REG_TOLERANCE, tol);
            write_reg(REG_MAX_SWEEPS, lim);
            queued = 0;
            while (queued < 100)
            begin
                pick = $urandom_range(0, 9);
                n = $urandom_range(1, 12);
                shape = (pick < 3) ? SHAPE_NOISE :
                        (pick < 5) ? SHAPE_RAMP :
                        (pick < 9) ? SHAPE_NEAR_FLAT : SHAPE_STUCK;
                push_vector(n, shape);
                queued += (shape == SHAPE_STUCK) ? 3 : n;
            end
            quiesce();
        end

        // full memory, then overflow, then recovery
        write_reg(REG_TOLERANCE, SWEEP_W'($urandom_range(0, 65535)));
        write_reg(REG_MAX_SWEEPS, SWEEP_W'($urandom_range(1, 3)));
        push_vector(DEPTH, SHAPE_NOISE);
        push_vector(DEPTH + int'($urandom_range(1, 4)), SHAPE_NEAR_FLAT);
        push_vector(5, SHAPE_RAMP);
        quiesce();

        repeat (64) @(posedge clk);
        if (fail_cnt == 0 && settle_q.size() == 0)
            $display("smoothing_stencil_until_flat_tb: PASS");
        else
            $display("smoothing_stencil_until_flat_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("smoothing_stencil_until_flat_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssuf_pkg.sv
rtl/ssuf_avg.sv
rtl/smoothing_stencil_until_flat.sv
rtl/ssuf_checker.sv
test/smoothing_stencil_until_flat_tb.sv
